### rtl/icmp_chk_pkg.sv
// Shared constants and types for the ICMP echo request checker.
// No dependencies; the core refers to these by scoped names.
package icmp_chk_pkg;

  localparam int unsigned MsgLenW = 16;
  localparam logic [MsgLenW-1:0] MinMsgLen = MsgLenW'(8);
  localparam logic [7:0] EchoRequest = 8'd8;
  localparam logic [7:0] EchoReply = 8'd0;
  localparam logic [15:0] SumGood = 16'hFFFF;

  typedef enum logic [1:0] {
    VerdictReply       = 2'd0,
    VerdictInvalid     = 2'd1,
    VerdictUnsupported = 2'd2
  } verdict_t;

  // Ones' complement add of two 16-bit words with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### rtl/icmp_echo_request_checker_core.sv
// ICMP echo request checker: byte-wide message in, one verdict per message out.
// Depends on icmp_chk_pkg (constants, verdict_t, oc_add).
//
// Usage
//   Input channel (in_valid / in_stall): one message byte per item, in wire
//   order, with last set on the final byte. src_addr and dst_addr are taken
//   from the first byte of each message only.
//   Output channel (out_valid / out_stall): one item per message, on its final
//   byte: verdict, rewritten type, addresses (swapped on an echo reply) and the
//   message length, which saturates at 65535.
//   Throughput: one byte per cycle, except while a final byte waits under
//   out_stall. Every byte passes an input register and one ones' complement
//   add with end-around carry before the state and the result register.
//   Result path: an accepted final byte is held in the input register, and
//   its verdict and fields are then written to the result register, which
//   drives the output channel.
//   Stall: while a result waits under out_stall, non-final bytes still flow;
//   a final byte waits in the input register and in_stall rises until the
//   result register frees up.
//   Reset: rst clears the running sum, counters, held fields and both valid
//   flags; the block is ready for a new message on the next cycle.
module icmp_echo_request_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [7:0]  reply_type,
  output logic [31:0] out_src,
  output logic [31:0] out_dst,
  output logic [icmp_chk_pkg::MsgLenW-1:0] msg_length
);

  localparam int unsigned LenW = icmp_chk_pkg::MsgLenW;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic [31:0] s1_src;
  logic [31:0] s1_dst;

  // per-message state
  logic [15:0]     word_sum;
  logic [7:0]      high_byte_hold;
  logic [LenW-1:0] byte_count;
  logic [7:0]      msg_type;
  logic [7:0]      msg_code;
  logic [31:0]     held_src;
  logic [31:0]     held_dst;
  logic            overlong;

  // result register
  logic                   r_valid;
  icmp_chk_pkg::verdict_t r_verdict;
  logic [7:0]             r_type;
  logic [31:0]            r_src;
  logic [31:0]            r_dst;
  logic [LenW-1:0]        r_len;

  logic advance;
  logic fire;
  logic in_take;

  logic [15:0]     word_sum_next;
  logic [7:0]      high_byte_hold_next;
  logic [LenW-1:0] byte_count_next;
  logic [7:0]      msg_type_next;
  logic [7:0]      msg_code_next;
  logic [31:0]     held_src_next;
  logic [31:0]     held_dst_next;
  logic            overlong_next;
  icmp_chk_pkg::verdict_t verdict_next;
  logic [7:0]      type_out_next;
  logic [31:0]     src_out_next;
  logic [31:0]     dst_out_next;

  // a non-final item never needs the result register
  assign advance = !s1_last || !r_valid || !out_stall;
  assign fire    = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    logic        first;
    logic        sat;
    logic        do_add;
    logic [15:0] word;
    first = (byte_count == '0);
    sat   = (byte_count == LenMax);

    held_src_next = first ? s1_src : held_src;
    held_dst_next = first ? s1_dst : held_dst;
    overlong_next = overlong || sat;
    byte_count_next = sat ? byte_count : byte_count + LenW'(1);
    msg_type_next = (!sat && first) ? s1_byte : msg_type;
    msg_code_next = (!sat && byte_count == LenW'(1)) ? s1_byte : msg_code;
    high_byte_hold_next = (!sat && !byte_count[0]) ? s1_byte : high_byte_hold;

    // odd position closes a word; a final byte at even position is padded
    do_add = 1'b0;
    word   = {high_byte_hold, s1_byte};
    if (!sat) begin
      if (byte_count[0]) begin
        do_add = 1'b1;
      end else if (s1_last) begin
        do_add = 1'b1;
        word   = {s1_byte, 8'd0};
      end
    end
    word_sum_next = do_add ? icmp_chk_pkg::oc_add(word_sum, word) : word_sum;

    verdict_next  = icmp_chk_pkg::VerdictUnsupported;
    type_out_next = msg_type_next;
    src_out_next  = held_src_next;
    dst_out_next  = held_dst_next;
    if (overlong_next || byte_count_next < icmp_chk_pkg::MinMsgLen
        || word_sum_next != icmp_chk_pkg::SumGood) begin
      verdict_next = icmp_chk_pkg::VerdictInvalid;
    end else if (msg_type_next == icmp_chk_pkg::EchoRequest) begin
      if (msg_code_next != 8'd0) begin
        verdict_next = icmp_chk_pkg::VerdictInvalid;
      end else begin
        verdict_next  = icmp_chk_pkg::VerdictReply;
        type_out_next = icmp_chk_pkg::EchoReply;
        src_out_next  = held_dst_next;
        dst_out_next  = held_src_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= data_byte;
      s1_last <= last;
      s1_src  <= src_addr;
      s1_dst  <= dst_addr;
    end
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && s1_last)) begin
      // clear for the next message
      word_sum       <= '0;
      high_byte_hold <= '0;
      byte_count     <= '0;
      msg_type       <= '0;
      msg_code       <= '0;
      held_src       <= '0;
      held_dst       <= '0;
      overlong       <= 1'b0;
    end else if (fire) begin
      word_sum       <= word_sum_next;
      high_byte_hold <= high_byte_hold_next;
      byte_count     <= byte_count_next;
      msg_type       <= msg_type_next;
      msg_code       <= msg_code_next;
      held_src       <= held_src_next;
      held_dst       <= held_dst_next;
      overlong       <= overlong_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last) begin
      r_verdict <= verdict_next;
      r_type    <= type_out_next;
      r_src     <= src_out_next;
      r_dst     <= dst_out_next;
      r_len     <= byte_count_next;
    end
    if (rst) begin
      r_valid <= 1'b0;
    end else if (fire && s1_last) begin
      r_valid <= 1'b1;
    end else if (!out_stall) begin
      r_valid <= 1'b0;
    end
  end

  assign out_valid  = r_valid;
  assign verdict    = r_verdict;
  assign reply_type = r_type;
  assign out_src    = r_src;
  assign out_dst    = r_dst;
  assign msg_length = r_len;

  a_overlong_count: assert property (@(posedge clk) disable iff (rst)
    overlong |-> byte_count == LenMax)
    else $error("overlong set with an unsaturated byte count");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && s1_last |=> byte_count == '0 && word_sum == 16'd0 && !overlong)
    else $error("message state not cleared after a final item");

  a_reply_fields: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_verdict == icmp_chk_pkg::VerdictReply |->
      r_type == icmp_chk_pkg::EchoReply && r_len >= icmp_chk_pkg::MinMsgLen)
    else $error("echo reply with bad type or short length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    r_valid && out_stall |=> r_valid && $stable(r_len) && $stable(r_src))
    else $error("waiting result overwritten");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_last && r_valid)
    else $error("input stalled without a blocked final item");

endmodule
